// ===== hw/rtl/fmfs_pkg.sv =====
// Shared types, constants and helper functions of the Fourier-mode field synthesis core.
// Used by the CORDIC unit, the datapath, the controller and the top level.
// No dependencies.
package fmfs_pkg;

    // Table sizes and angle resolution.
    localparam int MAX_SLAB_MODES = 256;
    localparam int MAX_TWOD_MODES = 256;
    localparam int ANGLE_BITS     = 16;

    localparam int SLAB_AW = $clog2(MAX_SLAB_MODES);
    localparam int TWOD_AW = $clog2(MAX_TWOD_MODES);
    localparam int MODE_AW = (SLAB_AW > TWOD_AW) ? SLAB_AW : TWOD_AW;
    localparam int IDX_W   = MODE_AW + 1;

    // Angle truncation mask applied before the CORDIC.
    localparam logic [31:0] ANGLE_MASK = ~((32'h1 << (32 - ANGLE_BITS)) - 32'h1);

    // CORDIC settings.
    localparam int          CORDIC_STEPS = 16;
    localparam logic [33:0] CORDIC_GAIN  = 34'd652032874;

    // Input commands.
    localparam logic [1:0] CMD_LOAD_SLAB = 2'd0;
    localparam logic [1:0] CMD_LOAD_TWOD = 2'd1;
    localparam logic [1:0] CMD_EVALUATE  = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] CFG_SLAB_COUNT = 3'd0;
    localparam logic [2:0] CFG_TWOD_COUNT = 3'd1;
    localparam logic [2:0] CFG_SLAB_EN    = 3'd2;
    localparam logic [2:0] CFG_TWOD_EN    = 3'd3;
    localparam logic [2:0] CFG_MEAN_FIELD = 3'd4;

    // One stored slab mode.
    typedef struct packed {
        logic [23:0] amp;
        logic [15:0] azimuth;
        logic [15:0] polar;
        logic [15:0] phase;
        logic [31:0] wave;
    } t_slab_mode;

    // One stored 2D mode.
    typedef struct packed {
        logic [23:0] amp;
        logic [15:0] azimuth;
        logic [15:0] phase;
        logic [31:0] wave;
    } t_twod_mode;

    // Datapath operations issued by the controller.
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LD_SLAB,
        OP_LD_TWOD,
        OP_EVAL_INIT,
        OP_RD_SLAB,
        OP_RD_TWOD,
        OP_SLAB_MUL,
        OP_TRIG_SLAB_T,
        OP_TRIG_POL,
        OP_TRIG_SLAB_AZ,
        OP_TRIG_TWOD_AZ,
        OP_TRIG_TWOD_T,
        OP_SAVE_T,
        OP_SAVE_POL,
        OP_SAVE_AZ,
        OP_SLAB_P1,
        OP_SLAB_P2,
        OP_SLAB_P3,
        OP_TWOD_U1,
        OP_TWOD_U2,
        OP_TWOD_U3,
        OP_TWOD_Q1,
        OP_TWOD_Q2,
        OP_AMP,
        OP_ACC,
        OP_OUT
    } t_dp_op;

    // Command from controller to datapath.
    typedef struct packed {
        t_dp_op             op;
        logic [MODE_AW-1:0] addr;
    } t_dp_cmd;

    // Status from datapath to controller.
    typedef struct packed {
        logic             cordic_done;
        logic             out_busy;
        logic             slab_en;
        logic             twod_en;
        logic [IDX_W-1:0] slab_n;
        logic [IDX_W-1:0] twod_n;
    } t_dp_stat;

    // Arctangent of 2^-i as a 32-bit turn fraction.
    function automatic logic [31:0] atan_turn(input logic [3:0] i);
        logic [31:0] r;
        case (i)
            4'd0:    r = 32'd536870912;
            4'd1:    r = 32'd316933406;
            4'd2:    r = 32'd167458907;
            4'd3:    r = 32'd85004756;
            4'd4:    r = 32'd42667331;
            4'd5:    r = 32'd21354465;
            4'd6:    r = 32'd10679838;
            4'd7:    r = 32'd5340245;
            4'd8:    r = 32'd2670163;
            4'd9:    r = 32'd1335087;
            4'd10:   r = 32'd667544;
            4'd11:   r = 32'd333772;
            4'd12:   r = 32'd166886;
            4'd13:   r = 32'd83443;
            4'd14:   r = 32'd41722;
            default: r = 32'd20861;
        endcase
        return r;
    endfunction

    // Round to nearest at bit 15, ties toward plus infinity.
    function automatic logic signed [63:0] rnd15(input logic signed [63:0] v);
        return (v + 64'sd16384) >>> 15;
    endfunction

endpackage

// ===== hw/rtl/fmfs_cordic.sv =====
// Iterative rotation-mode CORDIC giving cos and sin of a turn fraction in Q1.15.
// One micro-rotation per cycle; depends on fmfs_pkg.
module fmfs_cordic import fmfs_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [31:0]        i_turn,
    output logic               o_done,
    output logic signed [15:0] o_cos,
    output logic signed [15:0] o_sin
);

    logic               r_busy;
    logic               r_fin;
    logic               r_done;
    logic [3:0]         r_step;
    logic               r_flip;
    logic signed [33:0] r_x;
    logic signed [33:0] r_y;
    logic signed [33:0] r_z;
    logic signed [15:0] r_cos;
    logic signed [15:0] r_sin;

    logic [31:0]        w_turn;
    logic               w_flip;
    logic [31:0]        w_turn_fold;
    logic signed [33:0] w_atan;
    logic signed [33:0] w_xs;
    logic signed [33:0] w_ys;
    logic signed [18:0] w_xr;
    logic signed [18:0] w_yr;
    logic signed [19:0] w_xf;
    logic signed [19:0] w_yf;

    function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
        logic signed [15:0] r;
        if (v > 20'sd32767) begin
            r = 16'sh7fff;
        end else if (v < -20'sd32768) begin
            r = -16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    // Fold the angle into the right half plane.
    always_comb begin
        w_turn      = i_turn & ANGLE_MASK;
        w_flip      = w_turn[31] ^ w_turn[30];
        w_turn_fold = w_flip ? {~w_turn[31], w_turn[30:0]} : w_turn;
    end

    // Shifted terms of the current micro-rotation.
    assign w_atan = $signed({2'b00, atan_turn(r_step)});
    assign w_xs   = r_x >>> r_step;
    assign w_ys   = r_y >>> r_step;

    // Final rounding and unfolding.
    always_comb begin
        w_xr = 19'((r_x + 34'sd16384) >>> 15);
        w_yr = 19'((r_y + 34'sd16384) >>> 15);
        w_xf = r_flip ? -20'(w_xr) : 20'(w_xr);
        w_yf = r_flip ? -20'(w_yr) : 20'(w_yr);
    end

    // Control of the iteration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= r_fin;
            r_fin  <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 4'd1;
                if (r_step == 4'(CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end
        end
    end

    // Rotation vector and results.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= CORDIC_GAIN;
            r_y    <= '0;
            r_z    <= 34'($signed(w_turn_fold));
            r_flip <= w_flip;
        end else if (r_busy) begin
            if (!r_z[33]) begin
                r_x <= r_x - w_ys;
                r_y <= r_y + w_xs;
                r_z <= r_z - w_atan;
            end else begin
                r_x <= r_x + w_ys;
                r_y <= r_y - w_xs;
                r_z <= r_z + w_atan;
            end
        end
        if (r_fin) begin
            r_cos <= sat16(w_xf);
            r_sin <= sat16(w_yf);
        end
    end

    assign o_done = r_done;
    assign o_cos  = r_cos;
    assign o_sin  = r_sin;

endmodule

// ===== hw/rtl/fmfs_datapath.sv =====
// Datapath of the field synthesis core: mode tables, configuration registers,
// products, accumulators and the output register. Depends on fmfs_pkg and fmfs_cordic.
module fmfs_datapath import fmfs_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_dp_cmd       i_cmd,
    output t_dp_stat      o_stat,
    input  logic          i_cfg_valid,
    input  logic [2:0]    i_cfg_index,
    input  logic [31:0]   i_cfg_data,
    input  logic [7:0]    i_mode_index,
    input  logic [31:0]   i_wave_number,
    input  logic [15:0]   i_phase_offset,
    input  logic [15:0]   i_polar_angle,
    input  logic [15:0]   i_azimuth_angle,
    input  logic [23:0]   i_amplitude,
    input  logic [31:0]   i_pos_x,
    input  logic [31:0]   i_pos_y,
    input  logic [31:0]   i_pos_z,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output logic [40:0]   o_field_x,
    output logic [40:0]   o_field_y,
    output logic [31:0]   o_field_z
);

    // Mode tables.
    t_slab_mode r_slab_mem [MAX_SLAB_MODES];
    t_twod_mode r_twod_mem [MAX_TWOD_MODES];
    t_slab_mode r_sm;
    t_twod_mode r_tm;

    // Configuration.
    logic [8:0]  r_slab_cnt;
    logic [8:0]  r_twod_cnt;
    logic        r_slab_en;
    logic        r_twod_en;
    logic [31:0] r_mean;

    // Working registers.
    logic signed [31:0] r_px;
    logic signed [31:0] r_py;
    logic [31:0]        r_pz;
    logic [23:0]        r_zprod;
    logic signed [15:0] r_c;
    logic signed [15:0] r_s;
    logic signed [15:0] r_ca;
    logic signed [15:0] r_sa;
    logic signed [15:0] r_cp;
    logic signed [15:0] r_sp;
    logic signed [16:0] r_cc;
    logic signed [16:0] r_ss;
    logic signed [32:0] r_m1;
    logic signed [32:0] r_m2;
    logic signed [32:0] r_m3;
    logic signed [32:0] r_m4;
    logic signed [47:0] r_ux;
    logic signed [47:0] r_uy;
    logic [38:0]        r_u;
    logic [38:0]        r_p1;
    logic [6:0]         r_p2;
    logic signed [18:0] r_tx;
    logic signed [18:0] r_ty;
    logic               r_twod_mode;
    logic signed [43:0] r_ax;
    logic signed [43:0] r_ay;
    logic signed [47:0] r_sx;
    logic signed [47:0] r_sy;
    logic               r_out_valid;
    logic [40:0]        r_fx_out;
    logic [40:0]        r_fy_out;
    logic [31:0]        r_fz_out;

    // Combinational terms.
    logic [47:0]        w_zprod;
    logic [31:0]        w_slab_turn;
    logic [31:0]        w_twod_turn;
    logic [31:0]        w_trig_turn;
    logic               w_trig_start;
    logic               w_cordic_done;
    logic signed [15:0] w_cos;
    logic signed [15:0] w_sin;
    logic signed [31:0] w_pc;
    logic signed [31:0] w_ps;
    logic signed [63:0] w_cc;
    logic signed [63:0] w_ss;
    logic signed [32:0] w_m1;
    logic signed [32:0] w_m2;
    logic signed [32:0] w_m3;
    logic signed [32:0] w_m4;
    logic signed [31:0] w_q1;
    logic signed [31:0] w_q2;
    logic signed [63:0] w_fx;
    logic signed [63:0] w_fy;
    logic signed [63:0] w_gx;
    logic signed [63:0] w_gy;
    logic signed [47:0] w_ux;
    logic signed [47:0] w_uy;
    logic [47:0]        w_usum;
    logic [63:0]        w_p1;
    logic [13:0]        w_p2;
    logic signed [24:0] w_amp;
    logic signed [43:0] w_ax;
    logic signed [43:0] w_ay;
    logic signed [63:0] w_rx;
    logic signed [63:0] w_ry;
    logic [IDX_W-1:0]   w_slab_n;
    logic [IDX_W-1:0]   w_twod_n;

    function automatic logic [40:0] sat41(input logic signed [47:0] v);
        logic [40:0] r;
        if (v > 48'sd1099511627775) begin
            r = {1'b0, {40{1'b1}}};
        end else if (v < -48'sd1099511627776) begin
            r = {1'b1, 40'd0};
        end else begin
            r = v[40:0];
        end
        return r;
    endfunction

    // Shared trig unit.
    fmfs_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_trig_start),
        .i_turn  (w_trig_turn),
        .o_done  (w_cordic_done),
        .o_cos   (w_cos),
        .o_sin   (w_sin)
    );

    // Phase arguments.
    assign w_zprod     = r_sm.wave[23:0] * r_pz[23:0];
    assign w_slab_turn = {r_zprod, 8'd0} + {r_sm.phase, 16'd0};
    assign w_twod_turn = r_p1[38:7] + {r_p2, 25'd0} + {r_tm.phase, 16'd0};

    // Angle selection for the trig unit.
    always_comb begin
        w_trig_start = 1'b1;
        unique case (i_cmd.op)
            OP_TRIG_SLAB_T:  w_trig_turn = w_slab_turn;
            OP_TRIG_POL:     w_trig_turn = {r_sm.polar, 16'd0};
            OP_TRIG_SLAB_AZ: w_trig_turn = {r_sm.azimuth, 16'd0};
            OP_TRIG_TWOD_AZ: w_trig_turn = {r_tm.azimuth, 16'd0};
            OP_TRIG_TWOD_T:  w_trig_turn = w_twod_turn;
            default: begin
                w_trig_turn  = w_slab_turn;
                w_trig_start = 1'b0;
            end
        endcase
    end

    // Products and rounding.
    always_comb begin
        w_pc   = r_c * r_ca;
        w_ps   = r_s * r_sa;
        w_cc   = rnd15(64'(w_pc));
        w_ss   = rnd15(64'(w_ps));
        w_m1   = r_cc * r_cp;
        w_m2   = r_ss * r_sp;
        w_m3   = r_cc * r_sp;
        w_m4   = r_ss * r_cp;
        w_q1   = r_sp * r_s;
        w_q2   = r_cp * r_s;
        w_fx   = rnd15(64'(r_m1) + 64'(r_m2));
        w_fy   = rnd15(64'(r_m3) - 64'(r_m4));
        w_gx   = rnd15(64'(r_m1));
        w_gy   = rnd15(64'(r_m2));
        w_ux   = r_px * r_cp;
        w_uy   = r_py * r_sp;
        w_usum = r_ux + r_uy;
        w_p1   = r_tm.wave * r_u[31:0];
        w_p2   = r_tm.wave[6:0] * r_u[38:32];
        w_amp  = $signed({1'b0, (r_twod_mode ? r_tm.amp : r_sm.amp)});
        w_ax   = w_amp * r_tx;
        w_ay   = w_amp * r_ty;
        w_rx   = rnd15(64'(r_ax));
        w_ry   = rnd15(64'(r_ay));
    end

    // Mode tables: written by load items, read at the controller's address.
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_LD_SLAB && 32'(i_mode_index) < MAX_SLAB_MODES) begin
            r_slab_mem[SLAB_AW'(i_mode_index)] <= '{amp: i_amplitude,
                azimuth: i_azimuth_angle, polar: i_polar_angle,
                phase: i_phase_offset, wave: i_wave_number};
        end
        if (i_cmd.op == OP_RD_SLAB) begin
            r_sm <= r_slab_mem[SLAB_AW'(i_cmd.addr)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_LD_TWOD && 32'(i_mode_index) < MAX_TWOD_MODES) begin
            r_twod_mem[TWOD_AW'(i_mode_index)] <= '{amp: i_amplitude,
                azimuth: i_azimuth_angle, phase: i_phase_offset,
                wave: i_wave_number};
        end
        if (i_cmd.op == OP_RD_TWOD) begin
            r_tm <= r_twod_mem[TWOD_AW'(i_cmd.addr)];
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slab_cnt <= '0;
            r_twod_cnt <= '0;
            r_slab_en  <= 1'b1;
            r_twod_en  <= 1'b1;
            r_mean     <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SLAB_COUNT: r_slab_cnt <= i_cfg_data[8:0];
                CFG_TWOD_COUNT: r_twod_cnt <= i_cfg_data[8:0];
                CFG_SLAB_EN:    r_slab_en  <= i_cfg_data[0];
                CFG_TWOD_EN:    r_twod_en  <= i_cfg_data[0];
                CFG_MEAN_FIELD: r_mean     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Mode counts clamped to the table depth.
    assign w_slab_n = (32'(r_slab_cnt) > MAX_SLAB_MODES) ? IDX_W'(MAX_SLAB_MODES)
                                                         : IDX_W'(r_slab_cnt);
    assign w_twod_n = (32'(r_twod_cnt) > MAX_TWOD_MODES) ? IDX_W'(MAX_TWOD_MODES)
                                                         : IDX_W'(r_twod_cnt);

    // Working registers stepped by the controller.
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_EVAL_INIT: begin
                r_px <= i_pos_x;
                r_py <= i_pos_y;
                r_pz <= i_pos_z;
                r_sx <= '0;
                r_sy <= '0;
            end
            OP_SLAB_MUL: r_zprod <= w_zprod[23:0];
            OP_SAVE_T: begin
                r_c <= w_cos;
                r_s <= w_sin;
            end
            OP_SAVE_POL: begin
                r_ca <= w_cos;
                r_sa <= w_sin;
            end
            OP_SAVE_AZ: begin
                r_cp <= w_cos;
                r_sp <= w_sin;
            end
            OP_SLAB_P1: begin
                r_cc <= w_cc[16:0];
                r_ss <= w_ss[16:0];
            end
            OP_SLAB_P2: begin
                r_m1 <= w_m1;
                r_m2 <= w_m2;
                r_m3 <= w_m3;
                r_m4 <= w_m4;
            end
            OP_SLAB_P3: begin
                r_tx        <= w_fx[18:0];
                r_ty        <= w_fy[18:0];
                r_twod_mode <= 1'b0;
            end
            OP_TWOD_U1: begin
                r_ux <= w_ux;
                r_uy <= w_uy;
            end
            OP_TWOD_U2: r_u <= w_usum[38:0];
            OP_TWOD_U3: begin
                r_p1 <= w_p1[38:0];
                r_p2 <= w_p2[6:0];
            end
            OP_TWOD_Q1: begin
                r_m1 <= 33'(w_q1);
                r_m2 <= 33'(w_q2);
            end
            OP_TWOD_Q2: begin
                r_tx        <= w_gx[18:0];
                r_ty        <= w_gy[18:0];
                r_twod_mode <= 1'b1;
            end
            OP_AMP: begin
                r_ax <= w_ax;
                r_ay <= w_ay;
            end
            OP_ACC: begin
                r_sx <= r_sx + w_rx[47:0];
                r_sy <= r_twod_mode ? r_sy - w_ry[47:0] : r_sy + w_ry[47:0];
            end
            default: ;
        endcase
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.op == OP_OUT) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_OUT) begin
            r_fx_out <= sat41(r_sx);
            r_fy_out <= sat41(r_sy);
            r_fz_out <= r_mean;
        end
    end

    // Status to the controller.
    always_comb begin
        o_stat.cordic_done = w_cordic_done;
        o_stat.out_busy    = r_out_valid;
        o_stat.slab_en     = r_slab_en;
        o_stat.twod_en     = r_twod_en;
        o_stat.slab_n      = w_slab_n;
        o_stat.twod_n      = w_twod_n;
    end

    assign o_out_valid = r_out_valid;
    assign o_field_x   = r_fx_out;
    assign o_field_y   = r_fy_out;
    assign o_field_z   = r_fz_out;

endmodule

// ===== hw/rtl/fmfs_ctrl.sv =====
// Controller of the field synthesis core: accepts items and sequences the
// per-mode steps of an evaluation. Depends on fmfs_pkg.
module fmfs_ctrl import fmfs_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_command,
    input  t_dp_stat   i_stat,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [26:0] {
        S_IDLE     = 27'h0000001,
        S_SLAB_CHK = 27'h0000002,
        S_SLAB_RD  = 27'h0000004,
        S_SLAB_MUL = 27'h0000008,
        S_SLAB_CT  = 27'h0000010,
        S_SLAB_WT  = 27'h0000020,
        S_SLAB_CP  = 27'h0000040,
        S_SLAB_WP  = 27'h0000080,
        S_SLAB_CA  = 27'h0000100,
        S_SLAB_WA  = 27'h0000200,
        S_SLAB_P1  = 27'h0000400,
        S_SLAB_P2  = 27'h0000800,
        S_SLAB_P3  = 27'h0001000,
        S_TWOD_CHK = 27'h0002000,
        S_TWOD_RD  = 27'h0004000,
        S_TWOD_CA  = 27'h0008000,
        S_TWOD_WA  = 27'h0010000,
        S_TWOD_U1  = 27'h0020000,
        S_TWOD_U2  = 27'h0040000,
        S_TWOD_U3  = 27'h0080000,
        S_TWOD_CT  = 27'h0100000,
        S_TWOD_WT  = 27'h0200000,
        S_TWOD_Q1  = 27'h0400000,
        S_TWOD_Q2  = 27'h0800000,
        S_AMP      = 27'h1000000,
        S_ACC      = 27'h2000000,
        S_OUT      = 27'h4000000
    } t_state;

    t_state           r_state;
    t_state           n_state;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] n_idx;
    logic             r_in_twod;
    logic             n_in_twod;
    t_dp_op           w_op;

    // Next state and datapath operation.
    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_in_twod  = r_in_twod;
        w_op       = OP_NONE;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    case (i_command)
                        CMD_LOAD_SLAB: w_op = OP_LD_SLAB;
                        CMD_LOAD_TWOD: w_op = OP_LD_TWOD;
                        CMD_EVALUATE: begin
                            w_op      = OP_EVAL_INIT;
                            n_idx     = '0;
                            n_in_twod = 1'b0;
                            n_state   = S_SLAB_CHK;
                        end
                        default: ;
                    endcase
                end
            end
            S_SLAB_CHK: begin
                if (i_stat.slab_en && r_idx < i_stat.slab_n) begin
                    n_state = S_SLAB_RD;
                end else begin
                    n_idx     = '0;
                    n_in_twod = 1'b1;
                    n_state   = S_TWOD_CHK;
                end
            end
            S_SLAB_RD: begin
                w_op    = OP_RD_SLAB;
                n_state = S_SLAB_MUL;
            end
            S_SLAB_MUL: begin
                w_op    = OP_SLAB_MUL;
                n_state = S_SLAB_CT;
            end
            S_SLAB_CT: begin
                w_op    = OP_TRIG_SLAB_T;
                n_state = S_SLAB_WT;
            end
            S_SLAB_WT: begin
                if (i_stat.cordic_done) begin
                    w_op    = OP_SAVE_T;
                    n_state = S_SLAB_CP;
                end
            end
            S_SLAB_CP: begin
                w_op    = OP_TRIG_POL;
                n_state = S_SLAB_WP;
            end
            S_SLAB_WP: begin
                if (i_stat.cordic_done) begin
                    w_op    = OP_SAVE_POL;
                    n_state = S_SLAB_CA;
                end
            end
            S_SLAB_CA: begin
                w_op    = OP_TRIG_SLAB_AZ;
                n_state = S_SLAB_WA;
            end
            S_SLAB_WA: begin
                if (i_stat.cordic_done) begin
                    w_op    = OP_SAVE_AZ;
                    n_state = S_SLAB_P1;
                end
            end
            S_SLAB_P1: begin
                w_op    = OP_SLAB_P1;
                n_state = S_SLAB_P2;
            end
            S_SLAB_P2: begin
                w_op    = OP_SLAB_P2;
                n_state = S_SLAB_P3;
            end
            S_SLAB_P3: begin
                w_op    = OP_SLAB_P3;
                n_state = S_AMP;
            end
            S_TWOD_CHK: begin
                if (i_stat.twod_en && r_idx < i_stat.twod_n) begin
                    n_state = S_TWOD_RD;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_TWOD_RD: begin
                w_op    = OP_RD_TWOD;
                n_state = S_TWOD_CA;
            end
            S_TWOD_CA: begin
                w_op    = OP_TRIG_TWOD_AZ;
                n_state = S_TWOD_WA;
            end
            S_TWOD_WA: begin
                if (i_stat.cordic_done) begin
                    w_op    = OP_SAVE_AZ;
                    n_state = S_TWOD_U1;
                end
            end
            S_TWOD_U1: begin
                w_op    = OP_TWOD_U1;
                n_state = S_TWOD_U2;
            end
            S_TWOD_U2: begin
                w_op    = OP_TWOD_U2;
                n_state = S_TWOD_U3;
            end
            S_TWOD_U3: begin
                w_op    = OP_TWOD_U3;
                n_state = S_TWOD_CT;
            end
            S_TWOD_CT: begin
                w_op    = OP_TRIG_TWOD_T;
                n_state = S_TWOD_WT;
            end
            S_TWOD_WT: begin
                if (i_stat.cordic_done) begin
                    w_op    = OP_SAVE_T;
                    n_state = S_TWOD_Q1;
                end
            end
            S_TWOD_Q1: begin
                w_op    = OP_TWOD_Q1;
                n_state = S_TWOD_Q2;
            end
            S_TWOD_Q2: begin
                w_op    = OP_TWOD_Q2;
                n_state = S_AMP;
            end
            S_AMP: begin
                w_op    = OP_AMP;
                n_state = S_ACC;
            end
            S_ACC: begin
                w_op    = OP_ACC;
                n_idx   = r_idx + IDX_W'(1);
                n_state = r_in_twod ? S_TWOD_CHK : S_SLAB_CHK;
            end
            S_OUT: begin
                // Wait until the previous result has been taken.
                if (!i_stat.out_busy) begin
                    w_op    = OP_OUT;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_idx     <= '0;
            r_in_twod <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_in_twod <= n_in_twod;
        end
    end

    assign o_cmd.op   = w_op;
    assign o_cmd.addr = r_idx[MODE_AW-1:0];

endmodule

// ===== hw/rtl/fourier_mode_field_synthesis_core.sv =====
// Top level of the Fourier-mode field synthesis core.
// Instantiates fmfs_ctrl and fmfs_datapath; depends on fmfs_pkg.
//
// Load items (slab or 2D) write one mode each. An evaluate item sums the
// enabled slab modes, then the enabled 2D modes, through one shared 16-step
// CORDIC: a slab mode takes three rotations plus the product steps, a 2D mode
// two rotations plus its own product steps. The input is not taken while an
// evaluation runs; a finished result waits in the output register while the
// next item is accepted. Configuration writes are taken at any time with ready
// always high and must only be issued while the block is idle.
module fourier_mode_field_synthesis_core import fmfs_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Configuration write channel.
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [2:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data,
    // Input stream.
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // mode_index[7:0], wave_number[39:8], phase_offset[55:40], polar_angle[71:56],
    // azimuth_angle[87:72], amplitude[111:88], pos_x[143:112], pos_y[175:144],
    // pos_z[207:176]
    input  logic [207:0] s_axis_tdata,
    // command[1:0]
    input  logic [1:0]   s_axis_tuser,
    // Output stream.
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // field_x[40:0], field_y[81:41], field_z[113:82], zero fill[119:114]
    output logic [119:0] m_axis_tdata
);

    t_dp_cmd     w_cmd;
    t_dp_stat    w_stat;
    logic [40:0] w_field_x;
    logic [40:0] w_field_y;
    logic [31:0] w_field_z;

    fmfs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_command  (s_axis_tuser),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    fmfs_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_mode_index    (s_axis_tdata[7:0]),
        .i_wave_number   (s_axis_tdata[39:8]),
        .i_phase_offset  (s_axis_tdata[55:40]),
        .i_polar_angle   (s_axis_tdata[71:56]),
        .i_azimuth_angle (s_axis_tdata[87:72]),
        .i_amplitude     (s_axis_tdata[111:88]),
        .i_pos_x         (s_axis_tdata[143:112]),
        .i_pos_y         (s_axis_tdata[175:144]),
        .i_pos_z         (s_axis_tdata[207:176]),
        .o_out_valid     (m_axis_tvalid),
        .i_out_ready     (m_axis_tready),
        .o_field_x       (w_field_x),
        .o_field_y       (w_field_y),
        .o_field_z       (w_field_z)
    );

    // Configuration writes complete in the cycle they are offered.
    assign o_cfg_ready  = 1'b1;
    assign m_axis_tdata = {6'd0, w_field_z, w_field_y, w_field_x};

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench of fourier_mode_field_synthesis_core: loads mode tables,
// evaluates the field at positions and compares each result with its own predictor.
// Depends on fmfs_pkg and the core RTL only.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import fmfs_pkg::*;

    localparam logic [1:0] CMD_RESERVED = 2'd3;
    localparam int         SETTLE_CYCLES = 40;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  idx;
        logic [31:0] wave;
        logic [15:0] phase;
        logic [15:0] polar;
        logic [15:0] azimuth;
        logic [23:0] amp;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
    } t_item;

    typedef struct packed {
        logic [40:0] fx;
        logic [40:0] fy;
        logic [31:0] fz;
    } t_field;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic [2:0]   i_cfg_index = '0;
    logic [31:0]  i_cfg_data = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [207:0] s_axis_tdata = '0;
    logic [1:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [119:0] m_axis_tdata;

    fourier_mode_field_synthesis_core i_dut (.*);

    always #5 i_clk = ~i_clk;

    // Shadow copy of the mode tables and settings.
    t_slab_mode  slab_modes [MAX_SLAB_MODES];
    t_twod_mode  twod_modes [MAX_TWOD_MODES];
    logic [8:0]  slab_count = '0;
    logic [8:0]  twod_count = '0;
    logic        slab_on = 1'b1;
    logic        twod_on = 1'b1;
    logic [31:0] mean_bz = '0;

    t_field expected_fields [$];
    bit     failed = 1'b0;
    bit     calm = 1'b0;

    localparam logic [31:0] ATAN_STEP [16] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245,
        32'd2670163, 32'd1335087, 32'd667544, 32'd333772,
        32'd166886, 32'd83443, 32'd41722, 32'd20861
    };

    function automatic longint round15(input longint v);
        return (v + 64'sd16384) >>> 15;
    endfunction

    function automatic longint clip16(input longint v);
        return (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
    endfunction

    // Cosine and sine of a turn fraction through the rotation sequence, Q1.15.
    function automatic void rotate(input logic [31:0] turn, output longint c,
                                   output longint s);
        longint x, y, z, nx;
        logic [31:0] q;
        logic signed [31:0] zs;
        bit flip;
        turn = turn & ANGLE_MASK;
        q = turn + 32'h4000_0000;
        flip = q[31];
        if (flip) turn = turn - 32'h8000_0000;
        zs = turn;
        z = zs;
        x = 652032874;
        y = 0;
        for (int i = 0; i < 16; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z = z - longint'(ATAN_STEP[i]);
            end else begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z = z + longint'(ATAN_STEP[i]);
            end
            x = nx;
        end
        x = round15(x);
        y = round15(y);
        if (flip) begin
            x = -x;
            y = -y;
        end
        c = clip16(x);
        s = clip16(y);
    endfunction

    // Field at one position from the shadow tables.
    function automatic t_field field_at(input t_item it);
        longint sx, sy, c, s, ca, sa, cp, sp, cc, ss, fx, fy, a, u, px, py;
        logic [63:0] prod;
        logic [31:0] t;
        int n;
        t_field r;
        sx = 0;
        sy = 0;
        if (slab_on) begin
            n = (slab_count > MAX_SLAB_MODES) ? MAX_SLAB_MODES : slab_count;
            for (int i = 0; i < n; i++) begin
                prod = 64'(slab_modes[i].wave) * 64'(it.pos_z);
                t = {prod[23:0], 8'h0} + {slab_modes[i].phase, 16'h0};
                rotate(t, c, s);
                rotate({slab_modes[i].polar, 16'h0}, ca, sa);
                rotate({slab_modes[i].azimuth, 16'h0}, cp, sp);
                cc = round15(c * ca);
                ss = round15(s * sa);
                fx = round15(cc * cp + ss * sp);
                fy = round15(cc * sp - ss * cp);
                a = longint'(slab_modes[i].amp);
                sx += round15(a * fx);
                sy += round15(a * fy);
            end
        end
        if (twod_on) begin
            px = longint'(signed'(it.pos_x));
            py = longint'(signed'(it.pos_y));
            n = (twod_count > MAX_TWOD_MODES) ? MAX_TWOD_MODES : twod_count;
            for (int i = 0; i < n; i++) begin
                rotate({twod_modes[i].azimuth, 16'h0}, cp, sp);
                u = px * cp + py * sp;
                prod = 64'(twod_modes[i].wave) * 64'(u);
                t = prod[38:7] + {twod_modes[i].phase, 16'h0};
                rotate(t, c, s);
                a = longint'(twod_modes[i].amp);
                sx += round15(a * round15(sp * s));
                sy -= round15(a * round15(cp * s));
            end
        end
        if (sx > 64'sd1099511627775) sx = 64'sd1099511627775;
        if (sx < -64'sd1099511627776) sx = -64'sd1099511627776;
        if (sy > 64'sd1099511627775) sy = 64'sd1099511627775;
        if (sy < -64'sd1099511627776) sy = -64'sd1099511627776;
        r.fx = sx[40:0];
        r.fy = sy[40:0];
        r.fz = mean_bz;
        return r;
    endfunction

    // Update the shadow state for one accepted item.
    function automatic void apply_item(input t_item it);
        case (it.cmd)
            CMD_LOAD_SLAB: slab_modes[it.idx] = '{it.amp, it.azimuth, it.polar, it.phase,
                                                  it.wave};
            CMD_LOAD_TWOD: twod_modes[it.idx] = '{it.amp, it.azimuth, it.phase, it.wave};
            CMD_EVALUATE:  expected_fields.push_back(field_at(it));
            default: ;
        endcase
    endfunction

    // Send one item, with a random gap in front of it unless calm is set.
    task automatic send_item(input t_item it);
        if (!calm) begin
            while ($urandom_range(99) < 21) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.cmd;
        s_axis_tdata  <= {it.pos_z, it.pos_y, it.pos_x, it.amp, it.azimuth, it.polar,
                          it.phase, it.wave, it.idx};
        do @(posedge i_clk); while (!s_axis_tready);
        apply_item(it);
    endtask

    // Stop sending and let every pending evaluation come back.
    task automatic drain;
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (expected_fields.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] index, input logic [31:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (index)
            CFG_SLAB_COUNT: slab_count = value[8:0];
            CFG_TWOD_COUNT: twod_count = value[8:0];
            CFG_SLAB_EN:    slab_on = value[0];
            CFG_TWOD_EN:    twod_on = value[0];
            CFG_MEAN_FIELD: mean_bz = value;
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic t_item random_item(input logic [1:0] cmd, input logic [7:0] idx);
        t_item it;
        it.cmd = cmd;
        it.idx = idx;
        it.wave = $urandom();
        it.phase = $urandom();
        it.polar = $urandom();
        it.azimuth = $urandom();
        it.amp = $urandom();
        if ($urandom_range(1)) begin
            it.pos_x = $urandom();
            it.pos_y = $urandom();
            it.pos_z = $urandom();
        end else begin
            it.pos_x = 32'($signed($urandom_range(200)) - 100);
            it.pos_y = 32'($signed($urandom_range(200)) - 100);
            it.pos_z = 32'($signed($urandom_range(200)) - 100);
        end
        return it;
    endfunction

    // Output side: random stalls and the check of each transfer.
    always @(posedge i_clk) begin
        t_field got, want;
        if (m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tdata[40:0], m_axis_tdata[81:41], m_axis_tdata[113:82]};
            if (expected_fields.size() == 0) begin
                $error("field result with none expected");
                failed = 1'b1;
            end else begin
                want = expected_fields.pop_front();
                if (got.fx !== want.fx) begin
                    $error("field_x expected %0h actual %0h", want.fx, got.fx);
                    failed = 1'b1;
                end
                if (got.fy !== want.fy) begin
                    $error("field_y expected %0h actual %0h", want.fy, got.fy);
                    failed = 1'b1;
                end
                if (got.fz !== want.fz) begin
                    $error("field_z expected %0h actual %0h", want.fz, got.fz);
                    failed = 1'b1;
                end
            end
        end
        m_axis_tready <= calm || ($urandom_range(99) >= 21);
    end

    // Reset values, then extreme loads and positions on a few modes.
    task automatic test_directed;
        t_item it;
        it = random_item(CMD_EVALUATE, 8'd0);
        send_item(it);
        it.pos_x = 32'h8000_0000;
        send_item(it);
        it.cmd = CMD_RESERVED;
        send_item(it);
        for (int i = 0; i < 4; i++) begin
            it = random_item(CMD_LOAD_SLAB, 8'(i));
            it.wave = (i[0]) ? 32'hFFFF_FFFF : 32'h0;
            it.amp = (i < 2) ? 24'hFF_FFFF : 24'h0;
            it.phase = (i[1]) ? 16'hFFFF : 16'h0;
            it.polar = (i[0]) ? 16'h0 : 16'hFFFF;
            it.azimuth = (i[1]) ? 16'h0 : 16'hFFFF;
            send_item(it);
            it.cmd = CMD_LOAD_TWOD;
            it.azimuth = ~it.azimuth;
            send_item(it);
        end
        drain();
        write_reg(CFG_SLAB_COUNT, 32'd4);
        write_reg(CFG_TWOD_COUNT, 32'd4);
        write_reg(CFG_MEAN_FIELD, 32'h7FFF_FFFF);
        for (int i = 0; i < 4; i++) begin
            it = random_item(CMD_EVALUATE, 8'($urandom()));
            it.pos_x = (i[0]) ? 32'h7FFF_FFFF : 32'h8000_0000;
            it.pos_y = (i[1]) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            it.pos_z = (i < 2) ? 32'h8000_0000 : 32'hFFFF_FFFF;
            send_item(it);
        end
        drain();
        write_reg(CFG_MEAN_FIELD, 32'h8000_0000);
        write_reg(CFG_SLAB_EN, 32'd0);
        send_item(random_item(CMD_EVALUATE, 8'd0));
        drain();
        write_reg(CFG_SLAB_EN, 32'd1);
        write_reg(CFG_TWOD_EN, 32'd0);
        send_item(random_item(CMD_EVALUATE, 8'd0));
        drain();
        write_reg(CFG_TWOD_EN, 32'd1);
    endtask

    // Full tables, counts at and above the table depth.
    task automatic test_full_tables;
        for (int i = 0; i < MAX_SLAB_MODES; i++) begin
            send_item(random_item(CMD_LOAD_SLAB, 8'(i)));
            send_item(random_item(CMD_LOAD_TWOD, 8'(i)));
        end
        drain();
        write_reg(CFG_SLAB_COUNT, 32'h1FF);
        write_reg(CFG_TWOD_COUNT, 32'h1FF);
        send_item(random_item(CMD_EVALUATE, 8'd0));
        send_item(random_item(CMD_EVALUATE, 8'd0));
        drain();
        write_reg(CFG_SLAB_COUNT, 32'd256);
        write_reg(CFG_TWOD_COUNT, 32'd256);
        send_item(random_item(CMD_EVALUATE, 8'd0));
        drain();
    endtask

    // Random mix of loads and evaluations over several settings.
    task automatic test_random;
        t_item it;
        int r;
        for (int phase_n = 0; phase_n < 4; phase_n++) begin
            write_reg(CFG_SLAB_COUNT, 32'($urandom_range(16)));
            write_reg(CFG_TWOD_COUNT, 32'($urandom_range(16)));
            write_reg(CFG_SLAB_EN, 32'($urandom_range(3) != 0));
            write_reg(CFG_TWOD_EN, 32'($urandom_range(3) != 0));
            write_reg(CFG_MEAN_FIELD, $urandom());
            calm = (phase_n == 1);
            for (int k = 0; k < 25; k++) begin
                r = $urandom_range(99);
                if (r < 45) it = random_item(CMD_EVALUATE, 8'($urandom()));
                else if (r < 70) it = random_item(CMD_LOAD_SLAB, 8'($urandom_range(15)));
                else if (r < 95) it = random_item(CMD_LOAD_TWOD, 8'($urandom_range(15)));
                else it = random_item(CMD_RESERVED, 8'($urandom()));
                send_item(it);
            end
            calm = 1'b0;
            drain();
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_full_tables();
        test_random();
        if (!failed) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Guard against a hang.
    initial begin
        #20_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
